// ===== rtl/core/link_etx_estimator_assert.svh =====
// Assertion macros used by the link ETX estimator controller.
`ifndef LINK_ETX_ESTIMATOR_ASSERT_SVH
`define LINK_ETX_ESTIMATOR_ASSERT_SVH

// Checked only outside reset.
`define ETX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define ETX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/etx_pkg.sv =====
// Types and constants of the link ETX estimator.
`timescale 1ns / 1ps
package etx_pkg;

  localparam logic [1:0] OP_REPORT = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_SEED   = 2'd3;

  localparam logic [2:0] REG_CACHED_MODE     = 3'd0;
  localparam logic [2:0] REG_SAMPLING_WINDOW = 3'd1;
  localparam logic [2:0] REG_MIN_REPORTS     = 3'd2;
  localparam logic [2:0] REG_WARMUP_SAMPLES  = 3'd3;
  localparam logic [2:0] REG_POOR_LEVEL      = 3'd4;
  localparam logic [2:0] REG_POOR_LIMIT      = 3'd5;
  localparam logic [2:0] REG_UPDATE_CAP      = 3'd6;
  localparam logic [2:0] REG_VALUE_CAP       = 3'd7;

  localparam int         NUM_W     = 25;   // (attempts << 9)
  localparam logic [4:0] DIV_LAST  = 5'd24;
  localparam logic [2:0] SAMPLE_MAX = 3'd7;
  localparam logic [8:0] FAIL_LIMIT = 9'd32;
  localparam logic [15:0] COST_MAX  = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_LD, ST_EVAL, ST_DIV, ST_FIN, ST_WB
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [4:0]  neighbor;
    logic [7:0]  attempt_count;
    logic        acked;
    logic [15:0] elapsed_seconds;
    logic [15:0] seed_value;
  } in_t;

  typedef struct packed {
    logic [15:0] link_cost;
    logic        updated;
    logic        dropped;
  } out_t;

  typedef struct packed {
    logic        cached_mode;
    logic [7:0]  sampling_window;
    logic [7:0]  min_reports;
    logic [7:0]  warmup_samples;
    logic [7:0]  poor_attempts_level;
    logic [1:0]  poor_drop_limit;
    logic [15:0] update_cap;
    logic [15:0] value_cap;
  } cfg_t;

  typedef struct packed {
    logic [15:0] cost;
    logic [2:0]  samples;
    logic [1:0]  drops;
    logic [4:0]  pend;
    logic        prov;
    logic [15:0] wattempts;
    logic [7:0]  wreports;
    logic [7:0]  wacks;
    logic [7:0]  wtimer;
  } ent_t;

  typedef struct packed {
    logic load_item;
    logic load_entry;
    logic eval;
    logic div_step;
    logic fin;
    logic wb;
  } cmd_t;

  typedef struct packed {
    logic rec;
    logic div_need;
    logic div_done;
  } dp_stat_t;

endpackage

// ===== rtl/core/link_etx_estimator.sv =====
// Top level of the per-neighbor link ETX estimator.
`timescale 1ns / 1ps
// Link ETX estimator: keeps a cost (12 fraction bits) for each of NEIGHBORS
// entries and answers every item with one result beat carrying cost >> 4
// (plus pending failures), an updated flag and a dropped flag. Items are
// handled one at a time: table read, evaluate, then for a recompute a
// restoring divide by the ack count at one quotient bit per cycle, a fold
// step and write-back. A read, seed, tick without update or dropped report
// goes from evaluation straight to write-back; a recompute with no acks in
// the window skips the divide but keeps the fold step. The controller
// returns to idle between items, and write-back waits while the result
// register still holds a stalled beat. The table is a single-port memory
// with a valid bit per entry, so reset clears it at once. The result
// register lets the next item be accepted while the last result beat
// waits. Configuration is written through the cfg channel (always ready)
// and must only change while no item is in flight.
module link_etx_estimator #(
  parameter int NEIGHBORS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  etx_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_stall,
  output etx_pkg::out_t result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  import etx_pkg::*;

  cfg_t     cfg;
  cmd_t     cmd;
  dp_stat_t stat;
  out_t     res;
  logic     out_free;

  assign cfg_ready = 1'b1;

  // register file, reset to the documented defaults
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{cached_mode: 1'b0, sampling_window: 8'd0, min_reports: 8'd0,
               warmup_samples: 8'd1, poor_attempts_level: 8'd0,
               poor_drop_limit: 2'd0, update_cap: 16'd0, value_cap: 16'd0};
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CACHED_MODE:     cfg.cached_mode <= cfg_data[0];
        REG_SAMPLING_WINDOW: cfg.sampling_window <= cfg_data[7:0];
        REG_MIN_REPORTS:     cfg.min_reports <= cfg_data[7:0];
        REG_WARMUP_SAMPLES:  cfg.warmup_samples <= cfg_data[7:0];
        REG_POOR_LEVEL:      cfg.poor_attempts_level <= cfg_data[7:0];
        REG_POOR_LIMIT:      cfg.poor_drop_limit <= cfg_data[1:0];
        REG_UPDATE_CAP:      cfg.update_cap <= cfg_data;
        REG_VALUE_CAP:       cfg.value_cap <= cfg_data;
        default: ;
      endcase
    end
  end

  // result register: free when empty or when its beat leaves this cycle
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.wb) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      result <= res;
    end
  end

  etx_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .out_free   (out_free),
    .stat       (stat),
    .cmd        (cmd)
  );

  etx_dp #(.NEIGHBORS(NEIGHBORS)) u_dp (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (item),
    .cmd  (cmd),
    .stat (stat),
    .res  (res)
  );

endmodule

// ===== rtl/core/etx_dp.sv =====
// Datapath: neighbor table, update evaluation, serial divider, cost fold.
`timescale 1ns / 1ps
module etx_dp #(
  parameter int NEIGHBORS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  etx_pkg::cfg_t    cfg,
  input  etx_pkg::in_t     item,
  input  etx_pkg::cmd_t    cmd,
  output etx_pkg::dp_stat_t stat,
  output etx_pkg::out_t    res
);
  import etx_pkg::*;

  localparam int IDX_W = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
  localparam int ENT_W = $bits(ent_t);

  function automatic logic win_ready(ent_t x, logic [15:0] el, cfg_t c);
    logic [7:0] scx;
    logic       closed;
    scx    = {5'd0, x.samples};
    closed = (x.wtimer == 8'd0) || (x.wattempts == 16'hFFFF) || (x.wacks == 8'hFF);
    return ((scx == c.warmup_samples) && (el == 16'd0)) ||
           ((scx > c.warmup_samples) && closed &&
            ((x.wreports >= c.min_reports) || (x.wreports != x.wacks)));
  endfunction

  in_t                it;
  ent_t               e;
  logic [ENT_W-1:0]   mem [NEIGHBORS];
  logic [ENT_W-1:0]   rdata;
  logic [NEIGHBORS-1:0] vld;
  logic               rec, drp;
  logic [NUM_W-1:0]   quot;
  logic [7:0]         rem, dvs;
  logic [4:0]         cnt;

  logic [IDX_W-1:0]   idx;
  logic               inr;

  assign idx = IDX_W'(it.neighbor);
  assign inr = (32'(it.neighbor) < NEIGHBORS);

  // table
  always_ff @(posedge clk) begin
    if (cmd.wb && inr) begin
      mem[idx] <= e;
    end
    rdata <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.wb && inr) begin
      vld[idx] <= 1'b1;
    end
  end

  // evaluation of one operation
  ent_t        en;
  logic        rec_n, drp_n, go, poor;
  logic [8:0]  acc;
  logic [15:0] na;
  logic [7:0]  nd;

  always_comb begin
    en    = e;
    rec_n = 1'b0;
    drp_n = 1'b0;
    go    = 1'b1;
    poor  = 1'b0;
    acc   = '0;
    na    = 16'd0;
    nd    = 8'd1;
    case (it.opcode)
      OP_REPORT: begin
        if (e.samples < SAMPLE_MAX) begin
          poor = (cfg.poor_attempts_level != 8'd0) && it.acked &&
                 (it.attempt_count >= cfg.poor_attempts_level) &&
                 (e.drops < cfg.poor_drop_limit);
          if (poor) begin
            en.drops = e.drops + 2'd1;
            drp_n    = 1'b1;
            go       = 1'b0;
          end else begin
            en.samples = e.samples + 3'd1;
          end
        end
        if (go && cfg.cached_mode) begin
          en.wattempts = e.wattempts + {8'd0, it.attempt_count};
          en.wreports  = e.wreports + 8'd1;
          if (it.acked) begin
            en.wacks = e.wacks + 8'd1;
          end
          en.pend = '0;
          if (win_ready(en, 16'd0, cfg)) begin
            rec_n = 1'b1;
            na    = en.wattempts;
            nd    = en.wacks;
          end
        end else if (go) begin
          acc = {4'd0, e.pend} + {1'b0, it.attempt_count};
          if (!it.acked && (acc < FAIL_LIMIT)) begin
            en.pend = acc[4:0];
          end else begin
            en.pend = '0;
            if (e.cost != 16'd0) begin
              rec_n = 1'b1;
              na    = {7'd0, acc};
            end
          end
        end
      end
      OP_TICK: begin
        if (cfg.cached_mode && !e.prov) begin
          if ((e.wtimer != 8'd0) && (it.elapsed_seconds != 16'd0)) begin
            en.wtimer = (it.elapsed_seconds >= {8'd0, e.wtimer}) ? 8'd0 :
                        e.wtimer - it.elapsed_seconds[7:0];
          end
          if (win_ready(en, it.elapsed_seconds, cfg)) begin
            rec_n = 1'b1;
            na    = en.wattempts;
            nd    = en.wacks;
          end
        end
      end
      OP_SEED: begin
        en.cost = it.seed_value;
        en.prov = 1'b1;
      end
      default: ;
    endcase
    if (!inr) begin
      en    = e;
      rec_n = 1'b0;
      drp_n = 1'b0;
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [8:0] sh;
  logic       fits;
  always_comb begin
    sh   = {rem, quot[NUM_W-1]};
    fits = (sh >= {1'b0, dvs});
  end

  // fold of the new sample into the stored cost
  logic [17:0] ucap;
  logic [15:0] vcap, vnew;
  logic [NUM_W-1:0] v1;
  logic [27:0] v2;
  logic [7:0]  scw;
  ent_t        ef;
  always_comb begin
    scw  = {5'd0, e.samples};
    ucap = {cfg.update_cap[15:7], 9'd0};
    if (cfg.value_cap == 16'd0 || cfg.value_cap[15:11] != 5'd0) begin
      vcap = COST_MAX;
    end else begin
      vcap = {cfg.value_cap[10:7], 12'd0};
    end
    v1 = ((ucap != 18'd0) && (quot > NUM_W'(ucap))) ? NUM_W'(ucap) : quot;
    if (cfg.cached_mode && (scw <= cfg.warmup_samples)) begin
      v2 = {v1, 3'd0};
    end else begin
      v2 = {3'd0, v1} + 28'(e.cost) - 28'(e.cost[15:3]);
    end
    vnew = (v2 > 28'(vcap)) ? vcap : v2[15:0];
    ef       = e;
    ef.cost  = vnew;
    ef.prov  = 1'b0;
    ef.drops = '0;
    if (cfg.cached_mode && (scw >= cfg.warmup_samples)) begin
      ef.wattempts = '0;
      ef.wreports  = '0;
      ef.wacks     = '0;
      ef.wtimer    = cfg.sampling_window;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it <= item;
    end
    if (cmd.load_entry) begin
      e <= vld[idx] ? ent_t'(rdata) : '0;
    end
    if (cmd.eval) begin
      e    <= en;
      rec  <= rec_n;
      drp  <= drp_n;
      quot <= (nd == 8'd0) ? NUM_W'(COST_MAX) : {na, 9'd0};
      dvs  <= nd;
      rem  <= '0;
      cnt  <= '0;
    end
    if (cmd.div_step) begin
      rem  <= fits ? 8'(sh - {1'b0, dvs}) : sh[7:0];
      quot <= {quot[NUM_W-2:0], fits};
      cnt  <= cnt + 5'd1;
    end
    if (cmd.fin) begin
      e <= ef;
    end
  end

  assign stat.rec      = rec_n;
  assign stat.div_need = rec_n && (nd != 8'd0);
  assign stat.div_done = (cnt == DIV_LAST);

  // result of the finished entry
  logic [16:0] csum;
  always_comb begin
    csum = {1'b0, e.cost} + {3'd0, e.pend, 9'd0};
    res.updated = rec && inr;
    res.dropped = drp && inr;
    if (!inr) begin
      res.link_cost = 16'd0;
    end else if (cfg.cached_mode && ({5'd0, e.samples} < cfg.warmup_samples)) begin
      res.link_cost = COST_MAX;
    end else if (csum[16]) begin
      res.link_cost = COST_MAX >> 4;
    end else begin
      res.link_cost = {4'd0, csum[15:4]};
    end
  end

endmodule

// ===== rtl/core/etx_ctrl.sv =====
// Controller: sequences table read, evaluation, division and write-back.
`timescale 1ns / 1ps
module etx_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic              out_free,
  input  etx_pkg::dp_stat_t stat,
  output etx_pkg::cmd_t     cmd
);
  import etx_pkg::*;
  `include "link_etx_estimator_assert.svh"

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (item_valid) state_next = ST_RD;
      ST_RD:   state_next = ST_LD;
      ST_LD:   state_next = ST_EVAL;
      ST_EVAL: begin
        if (stat.div_need) state_next = ST_DIV;
        else if (stat.rec) state_next = ST_FIN;
        else state_next = ST_WB;
      end
      ST_DIV:  if (stat.div_done) state_next = ST_FIN;
      ST_FIN:  state_next = ST_WB;
      ST_WB:   if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        item_stall    = 1'b0;
        cmd.load_item = item_valid;
      end
      ST_LD:   cmd.load_entry = 1'b1;
      ST_EVAL: cmd.eval = 1'b1;
      ST_DIV:  cmd.div_step = 1'b1;
      ST_FIN:  cmd.fin = 1'b1;
      ST_WB:   cmd.wb = out_free;
      default: ;
    endcase
  end

  `ETX_ASSERT(a_cmd_onehot, $onehot0(cmd), "more than one datapath command")
  `ETX_ASSERT(a_load_to_rd, cmd.load_item |=> state == ST_RD, "item load not followed by read")
  `ETX_ASSERT(a_div_end, (state == ST_DIV && stat.div_done) |=> state == ST_FIN, "divide overrun")
  `ETX_ASSERT_ALWAYS(a_stall_busy, (state != ST_IDLE) |-> item_stall, "item taken while busy")

endmodule
